[design/b64u_pkg.sv]
// Shared types and constants for the base64url decoder.
// Depends on nothing; imported by the interfaces and all decoder modules.
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

    // End reason of a string; STOP_NONE while still decoding
    typedef enum logic [1:0] {
        STOP_NONE  = 2'd0,
        STOP_PAD   = 2'd1,
        STOP_BAD   = 2'd2,
        STOP_TRUNC = 2'd3
    } stop_reason_t;

    // Result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Field widths fixed by the character and result formats
    localparam int CHAR_W  = 8;
    localparam int TOTAL_W = 16;
    localparam int CAP_W   = 16;
    localparam int ACC_W   = 16;
    localparam int PEND_W  = 3;

    // Characters with a special meaning
    localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    // Sextet codes of the two punctuation characters and the digit and lowercase bases
    localparam logic [5:0] SEXTET_DASH  = 6'd62;
    localparam logic [5:0] SEXTET_UNDER = 6'd63;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_LOWER = 6'd26;

    // Result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    typedef struct packed {
        logic                ok;
        logic [5:0]          value;
    } sextet_t;

    typedef struct packed {
        logic                kind;
        logic [CHAR_W-1:0]   data_byte;
        logic [TOTAL_W-1:0]  byte_total;
        stop_reason_t        end_reason;
        logic                last_result;
    } result_t;

    // Up to two results per character; second_en only together with first_en
    typedef struct packed {
        logic    first_en;
        logic    second_en;
        result_t first;
        result_t second;
    } res_push_t;

    // Map one URL-safe character to its 6-bit value
    function automatic sextet_t b64u_sextet(input logic [CHAR_W-1:0] c);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = 6'd0;
        if (c >= "A" && c <= "Z") begin
            s.value = 6'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            s.value = 6'(c - "a") + SEXTET_LOWER;
        end else if (c >= "0" && c <= "9") begin
            s.value = 6'(c - "0") + SEXTET_DIGIT;
        end else if (c == "-") begin
            s.value = SEXTET_DASH;
        end else if (c == "_") begin
            s.value = SEXTET_UNDER;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[design/b64u_if.sv]
// Handshake channels of the base64url decoder: characters in, results out.
// Depends on b64u_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface b64u_char_if;
    import b64u_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface b64u_result_if;
    import b64u_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [CHAR_W-1:0]  data_byte;
    logic [TOTAL_W-1:0] byte_total;
    logic [1:0]         end_reason;
    logic               last_result;

    modport source (output valid, output kind, output data_byte, output byte_total,
                    output end_reason, output last_result, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_total,
                    input end_reason, input last_result, output ready);
endinterface

`default_nettype wire

[design/b64u_result_fifo.sv]
// Small result queue: takes up to two results per cycle, hands out one when the sink is ready.
// Depends on b64u_pkg and the b64u_result_if channel.
`timescale 1ns / 1ps
`default_nettype none

module b64u_result_fifo
    import b64u_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire res_push_t push,
    output logic           has_room,
    b64u_result_if.source  result_ch
);

    result_t                slot_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg;
    logic [RES_PTR_W-1:0]   wr_ptr_next;
    logic [RES_PTR_W-1:0]   wr_ptr_plus1;
    logic [RES_PTR_W-1:0]   rd_ptr_reg;
    logic [RES_PTR_W-1:0]   rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg;
    logic [RES_CNT_W-1:0]   count_next;
    logic [RES_CNT_W-1:0]   push_n;
    logic                   pop;
    result_t                head;

    // Room for a full pair of results from the next character
    assign has_room = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));

    assign pop          = result_ch.valid && result_ch.ready;
    assign push_n       = RES_CNT_W'(push.first_en) + RES_CNT_W'(push.second_en);
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + push_n - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store results in order
    always_ff @(posedge clk)
    begin
        if (push.first_en)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_en)
        begin
            slot_reg[wr_ptr_plus1] <= push.second;
        end
    end

    // Present the oldest result
    assign head                  = slot_reg[rd_ptr_reg];
    assign result_ch.valid       = (count_reg != '0);
    assign result_ch.kind        = head.kind;
    assign result_ch.data_byte   = head.data_byte;
    assign result_ch.byte_total  = head.byte_total;
    assign result_ch.end_reason  = head.end_reason;
    assign result_ch.last_result = head.last_result;

endmodule

`default_nettype wire

[design/base64url_decoder.sv]
// Base64url decoder top level: character decode, bit accumulator, byte count.
// Depends on b64u_pkg, b64u_if and b64u_result_fifo.
// Results: a character's results enter the result queue at its transfer and are offered in order.
// Throughput: one character per cycle while the four-entry result queue has room
// for two more results; a character that yields a byte and a summary puts both
// into the queue, which hands them out on the result port one at a time.
// Reset: clears the decoding state and the queue, sets the capacity register to 65535.
`timescale 1ns / 1ps
`default_nettype none

module base64url_decoder
    import b64u_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    b64u_char_if.sink             char_ch,
    b64u_result_if.source         result_ch
);

    localparam int CMP_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

    logic [CAP_W-1:0]       cap_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       acc_next;
    logic [PEND_W-1:0]      pend_reg;
    logic [PEND_W-1:0]      pend_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    stop_reason_t           stop_reg;
    stop_reason_t           stop_next;

    logic                   fire;
    logic                   has_room;
    logic                   is_space;
    logic                   active;
    sextet_t                sextet;
    logic [ACC_W-1:0]       acc_shift;
    logic [PEND_W:0]        pend_sum;
    logic                   byte_ready;
    logic [PEND_W-1:0]      pend_after;
    logic                   full;
    logic                   emit_byte;
    logic [CMP_W-1:0]       count_wide;
    logic [CMP_W-1:0]       cap_wide;
    logic [CMP_W-1:0]       total_wide;
    logic [ACC_W-1:0]       byte_word;
    result_t                data_res;
    result_t                sum_res;
    res_push_t              push;

    assign fire          = char_ch.valid && char_ch.ready;
    assign char_ch.ready = has_room;

    // Hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '1;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Classify the character and fold its sextet into the accumulator
    assign is_space   = (char_ch.char_in >= CHAR_TAB && char_ch.char_in <= CHAR_CR) ||
                        (char_ch.char_in == CHAR_SPACE);
    assign active     = (stop_reg == STOP_NONE) && !is_space;
    assign sextet     = b64u_sextet(char_ch.char_in);
    assign acc_shift  = {acc_reg[ACC_W-7:0], sextet.value};
    assign pend_sum   = {1'b0, pend_reg} + (PEND_W + 1)'(6);
    assign byte_ready = pend_sum[PEND_W];
    assign pend_after = pend_sum[PEND_W-1:0];
    assign byte_word  = acc_shift >> pend_after;

    // Capacity check against the count before this byte
    assign count_wide = CMP_W'(count_reg);
    assign cap_wide   = CMP_W'(cap_reg);
    assign full       = (count_wide >= cap_wide) || (&count_reg);

    // Next decoding state
    always_comb
    begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        stop_next  = stop_reg;
        emit_byte  = 1'b0;
        if (active)
        begin
            priority if (char_ch.char_in == CHAR_PAD || char_ch.char_in == CHAR_NUL)
            begin
                stop_next = STOP_PAD;
            end
            else if (!sextet.ok)
            begin
                stop_next = STOP_BAD;
            end
            else
            begin
                acc_next  = acc_shift;
                pend_next = pend_after;
                if (byte_ready)
                begin
                    if (full)
                    begin
                        stop_next = STOP_TRUNC;
                    end
                    else
                    begin
                        emit_byte  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Build the data and summary results
    assign total_wide = CMP_W'(count_next);

    always_comb
    begin
        data_res             = '0;
        data_res.kind        = KIND_DATA;
        data_res.data_byte   = byte_word[CHAR_W-1:0];
        data_res.byte_total  = '0;
        data_res.end_reason  = STOP_NONE;
        data_res.last_result = !char_ch.last_char;

        sum_res              = '0;
        sum_res.kind         = KIND_SUMMARY;
        sum_res.data_byte    = '0;
        sum_res.byte_total   = (stop_next == STOP_TRUNC) ? '0 : total_wide[TOTAL_W-1:0];
        sum_res.end_reason   = stop_next;
        sum_res.last_result  = 1'b1;
    end

    // Queue the results of this transfer in order
    always_comb
    begin
        push           = '0;
        push.first     = emit_byte ? data_res : sum_res;
        push.second    = sum_res;
        push.first_en  = fire && (emit_byte || char_ch.last_char);
        push.second_en = fire && emit_byte && char_ch.last_char;
    end

    // Advance state on each transfer; clear it at the end of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
            stop_reg  <= STOP_NONE;
        end
        else if (fire)
        begin
            if (char_ch.last_char)
            begin
                acc_reg   <= '0;
                pend_reg  <= '0;
                count_reg <= '0;
                stop_reg  <= STOP_NONE;
            end
            else
            begin
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                count_reg <= count_next;
                stop_reg  <= stop_next;
            end
        end
    end

    b64u_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (has_room),
        .result_ch (result_ch)
    );

    // A summary always closes the results of its character
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && (result_ch.kind == KIND_SUMMARY) |-> result_ch.last_result)
        else $error("summary result without last_result");

    // Data results carry no count and no reason
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && (result_ch.kind == KIND_DATA) |->
            (result_ch.byte_total == '0) && (result_ch.end_reason == STOP_NONE))
        else $error("data result with summary fields set");

    // The end of a string clears the decoding state
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && char_ch.last_char |=>
            (pend_reg == '0) && (count_reg == '0) && (stop_reg == STOP_NONE))
        else $error("decoding state not cleared after last character");

    // Pending bits stay even
    a_pend_even: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[0])
        else $error("odd pending bit count");

endmodule

`default_nettype wire
